@@ hdl/sv39_page_walker_assert.svh @@
// Assertion macros for the page walker
`ifndef SV39_PAGE_WALKER_ASSERT_SVH
`define SV39_PAGE_WALKER_ASSERT_SVH

// antecedent holds -> consequent in the same cycle
`define SV39PW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds -> consequent in the next cycle
`define SV39PW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/sv39pw_pkg.sv @@
package sv39pw_pkg;

  typedef enum logic [1:0] {
    KIND_READ       = 2'd0,
    KIND_DONE       = 2'd1,
    KIND_UNEXPECTED = 2'd2
  } kind_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_RESP  = 1'b1
  } op_e;

  localparam logic [3:0] MODE_SV39  = 4'd8;
  localparam logic [1:0] LEVEL_ROOT = 2'd2;
  localparam logic [1:0] LEVEL_LAST = 2'd0;

  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 120;

  typedef struct packed {
    op_e          operation;
    logic [63:0]  satp;
    logic [38:0]  virt_addr;
    logic [63:0]  pte_data;
  } req_t;

  typedef struct packed {
    kind_e        kind;
    logic [55:0]  read_address;
    logic [55:0]  xlat_addr;
    logic         fault;
  } res_t;

  typedef struct packed {
    logic         busy;
    logic [1:0]   level;
    logic [38:0]  vaddr;
  } walk_state_t;

  function automatic logic [55:0] pte_addr(logic [43:0] ppn, logic [38:0] va,
                                           logic [1:0] level);
    logic [8:0] vpn;
    unique case (level)
      2'd0:    vpn = va[20:12];
      2'd1:    vpn = va[29:21];
      2'd2:    vpn = va[38:30];
      default: vpn = '0;
    endcase
    return {ppn, 12'b0} + {44'b0, vpn, 3'b0};
  endfunction

  // superpage: keep 12 + 9 * level offset bits of the va
  function automatic logic [55:0] leaf_pa(logic [43:0] ppn, logic [38:0] va,
                                          logic [1:0] level);
    logic [38:0] mask;
    unique case (level)
      2'd0:    mask = 39'h0000000FFF;
      2'd1:    mask = 39'h00001FFFFF;
      2'd2:    mask = 39'h003FFFFFFF;
      default: mask = 39'h7FFFFFFFFF;
    endcase
    return {ppn, 12'b0} | {17'b0, va & mask};
  endfunction

endpackage

@@ hdl/sv39_page_walker.sv @@
// A request is registered first in the input register and its result then in the
// result register, from which it is taken.
// Throughput: one request per cycle unless the output is stalled; the walk
// step is one pass of shift/mask/add logic between the input and result
// registers. Reset (async, active low): walker idle, level and saved va
// cleared, both pipeline registers empty.
module sv39_page_walker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: satp[63:0], virt_addr[102:64], pte_data[166:103], zero pad
  input  logic [sv39pw_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: operation[0]
  input  logic [0:0]                          s_axis_tuser_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: read_address[55:0], xlat_addr[111:56], fault[112], zero pad
  output logic [sv39pw_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // tuser: kind[1:0]
  output logic [1:0]                          m_axis_tuser_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i
);
  import sv39pw_pkg::*;

  logic        advance;
  logic        in_valid;
  logic        fire;
  req_t        req;
  res_t        res;
  res_t        res_d, res_q;
  walk_state_t state_d, state_q, state_nxt;
  logic        out_valid_d, out_valid_q;

  assign advance = !out_valid_q || m_axis_tready_i;
  assign fire = in_valid && advance;

  sv39pw_in_reg u_in_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .advance_i      (advance),
    .valid_o        (in_valid),
    .req_o          (req)
  );

  sv39pw_step u_step (
    .req_i(req),
    .cur_i(state_q),
    .nxt_o(state_nxt),
    .res_o(res)
  );

  always_comb begin
    state_d = state_q;
    res_d = res_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      state_d = state_nxt;
      res_d = res;
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o = res_q.kind;
  assign m_axis_tdata_o = {7'b0, res_q.fault, res_q.xlat_addr, res_q.read_address};

`include "sv39_page_walker_assert.svh"

  `SV39PW_ASSERT_IMPL(a_fault_only_done, out_valid_q && res_q.fault, res_q.kind == KIND_DONE)
  `SV39PW_ASSERT_NEXT(a_read_keeps_busy, fire && res.kind == KIND_READ, state_q.busy)
  `SV39PW_ASSERT_NEXT(a_held_in_stall, in_valid && !advance, in_valid && $stable(req))

endmodule

@@ hdl/sv39pw_in_reg.sv @@
module sv39pw_in_reg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [sv39pw_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input  logic [0:0]                         s_axis_tuser_i,
  input  logic                               advance_i,
  output logic                               valid_o,
  output sv39pw_pkg::req_t                   req_o
);
  import sv39pw_pkg::*;

  logic valid_d, valid_q;
  req_t req_d, req_q;
  logic load;

  assign s_axis_tready_o = !valid_q || advance_i;
  assign load = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    req_d = req_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      req_d.operation = op_e'(s_axis_tuser_i[0]);
      req_d.satp = s_axis_tdata_i[63:0];
      req_d.virt_addr = s_axis_tdata_i[102:64];
      req_d.pte_data = s_axis_tdata_i[166:103];
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign valid_o = valid_q;
  assign req_o = req_q;

endmodule

@@ hdl/sv39pw_step.sv @@
module sv39pw_step (
  input  sv39pw_pkg::req_t        req_i,
  input  sv39pw_pkg::walk_state_t cur_i,
  output sv39pw_pkg::walk_state_t nxt_o,
  output sv39pw_pkg::res_t        res_o
);
  import sv39pw_pkg::*;

  logic [43:0] pte_ppn;

  assign pte_ppn = req_i.pte_data[53:10];

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    unique case (req_i.operation)
      OP_START: begin
        if (req_i.satp[63:60] != MODE_SV39) begin
          res_o.kind = KIND_DONE;
          res_o.fault = 1'b1;
          nxt_o.busy = 1'b0;
          nxt_o.level = LEVEL_LAST;
        end else begin
          nxt_o.busy = 1'b1;
          nxt_o.level = LEVEL_ROOT;
          nxt_o.vaddr = req_i.virt_addr;
          res_o.kind = KIND_READ;
          res_o.read_address = pte_addr(req_i.satp[43:0], req_i.virt_addr, LEVEL_ROOT);
        end
      end
      OP_RESP: begin
        if (!cur_i.busy) begin
          res_o.kind = KIND_UNEXPECTED;
        end else if (!req_i.pte_data[0]) begin
          res_o.kind = KIND_DONE;
          res_o.fault = 1'b1;
          nxt_o.busy = 1'b0;
          nxt_o.level = LEVEL_LAST;
        end else if (req_i.pte_data[3:1] != 3'b000) begin
          res_o.kind = KIND_DONE;
          res_o.xlat_addr = leaf_pa(pte_ppn, cur_i.vaddr, cur_i.level);
          nxt_o.busy = 1'b0;
          nxt_o.level = LEVEL_LAST;
        end else if (cur_i.level == LEVEL_LAST) begin
          res_o.kind = KIND_DONE;
          res_o.fault = 1'b1;
          nxt_o.busy = 1'b0;
        end else begin
          nxt_o.level = cur_i.level - 2'd1;
          res_o.kind = KIND_READ;
          res_o.read_address = pte_addr(pte_ppn, cur_i.vaddr, cur_i.level - 2'd1);
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

@@ tb/tb_sv39_page_walker.sv @@
`timescale 1ns / 100ps

module tb_sv39_page_walker;
  import sv39pw_pkg::*;

  localparam int unsigned ITEM_COUNT  = 850;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 8;

  typedef struct packed {
    op_e         op;
    logic [63:0] satp;
    logic [38:0] va;
    logic [63:0] pte;
    bit          typed;
    res_t        want;
  } script_row_t;

  localparam res_t NO_RES = '{KIND_READ, 56'h0, 56'h0, 1'b0};
  localparam res_t UNEXP  = '{KIND_UNEXPECTED, 56'h0, 56'h0, 1'b0};
  localparam res_t FAULT  = '{KIND_DONE, 56'h0, 56'h0, 1'b1};

  localparam int unsigned SCRIPT_LEN = 25;

  // idle walk, bad modes, walk extremes, aborts, leaves at every level, level 0 miss
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_RESP,  64'h0, 39'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, UNEXP},
    '{OP_START, 64'h0, 39'h7F_FFFF_FFFF, 64'h0, 1'b1, FAULT},
    '{OP_START, 64'hFFFF_FFFF_FFFF_FFFF, 39'h0, 64'h0, 1'b1, FAULT},
    '{OP_START, 64'h8FFF_FFFF_FFFF_FFFF, 39'h7F_FFFF_FFFF, 64'h0, 1'b1,
      '{KIND_READ, 56'hFF_FFFF_FFFF_FFF8, 56'h0, 1'b0}},
    '{OP_RESP,  64'h0, 39'h0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, FAULT},
    '{OP_RESP,  64'h0, 39'h0, 64'h0, 1'b1, UNEXP},
    '{OP_START, 64'h8000_0000_0000_0000, 39'h0, 64'h0, 1'b1, NO_RES},
    '{OP_RESP,  64'h0, 39'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{KIND_DONE, 56'h0, 56'hFF_FFFF_FFFF_F000, 1'b0}},
    '{OP_START, 64'h8FFF_F000_0123_4567, 39'h7F_FFFF_FFFF, 64'h0, 1'b0, NO_RES},
    '{OP_RESP,  64'h0, 39'h0, 64'h0000_0000_2AF3_7801, 1'b0, NO_RES},
    '{OP_RESP,  64'h0, 39'h0, 64'hFFFF_FFFF_FFFF_FFF1, 1'b0, NO_RES},
    '{OP_RESP,  64'h0, 39'h0, 64'h0000_0000_0000_0001, 1'b1, FAULT},
    '{OP_START, 64'h8000_0FED_CBA9_8765, 39'h55_5555_5555, 64'h0, 1'b0, NO_RES},
    '{OP_RESP,  64'h0, 39'h0, 64'h0000_0000_1234_5401, 1'b0, NO_RES},
    '{OP_RESP,  64'h0, 39'h0, 64'h0000_0000_0ABC_DC05, 1'b0, NO_RES},
    '{OP_START, 64'h8000_0000_0000_1000, 39'h2A_AAAA_AAAA, 64'h0, 1'b0, NO_RES},
    '{OP_RESP,  64'h0, 39'h0, 64'h0000_0000_0000_0401, 1'b0, NO_RES},
    '{OP_RESP,  64'h0, 39'h0, 64'h0000_0000_0000_0801, 1'b0, NO_RES},
    '{OP_RESP,  64'h0, 39'h0, 64'h0000_0000_0765_4009, 1'b0, NO_RES},
    '{OP_START, 64'h8000_0000_0000_0001, 39'h00_0000_1FFF, 64'h0, 1'b0, NO_RES},
    '{OP_START, 64'h8000_0000_0000_0002, 39'h40_0000_0000, 64'h0, 1'b0, NO_RES},
    '{OP_RESP,  64'h0, 39'h0, 64'h0000_0000_0003_0003, 1'b0, NO_RES},
    '{OP_START, 64'h8000_0000_0000_0003, 39'h1, 64'h0, 1'b0, NO_RES},
    '{OP_START, 64'h9000_0000_0000_0003, 39'h0, 64'h0, 1'b1, FAULT},
    '{OP_RESP,  64'h0, 39'h0, 64'h0000_0000_0000_000F, 1'b1, UNEXP}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [0:0]            s_axis_tuser_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;

  sv39_page_walker i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tvalid_o,
    .m_axis_tready_i
  );

  // walker state as predicted
  logic        walker_busy;
  logic [1:0]  walker_level;
  logic [38:0] walker_va;

  res_t        expected_results [$];
  res_t        head;
  int unsigned sent;
  int unsigned received;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned hold;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [55:0] table_slot(logic [43:0] ppn, logic [38:0] va,
                                             logic [1:0] level);
    logic [8:0] vpn;
    vpn = 9'((va >> (12 + 9 * level)) & 39'h1FF);
    return {ppn, 12'h0} + (56'(vpn) << 3);
  endfunction

  function automatic res_t walk_step(op_e op, logic [63:0] satp, logic [38:0] va,
                                     logic [63:0] pte);
    res_t        r;
    logic [43:0] ppn;
    logic [55:0] span;
    r = '0;
    if (op == OP_START) begin
      if (satp[63:60] != MODE_SV39) begin
        walker_busy  = 1'b0;
        walker_level = LEVEL_LAST;
        r.kind       = KIND_DONE;
        r.fault      = 1'b1;
      end else begin
        walker_busy    = 1'b1;
        walker_level   = LEVEL_ROOT;
        walker_va      = va;
        r.kind         = KIND_READ;
        r.read_address = table_slot(satp[43:0], va, LEVEL_ROOT);
      end
    end else if (!walker_busy) begin
      r.kind = KIND_UNEXPECTED;
    end else begin
      ppn = pte[53:10];
      if (!pte[0]) begin
        walker_busy  = 1'b0;
        walker_level = LEVEL_LAST;
        r.kind       = KIND_DONE;
        r.fault      = 1'b1;
      end else if (pte[3:1] != 3'b000) begin
        span         = (56'd1 << (12 + 9 * walker_level)) - 56'd1;
        r.kind       = KIND_DONE;
        r.xlat_addr  = {ppn, 12'h0} | (56'(walker_va) & span);
        walker_busy  = 1'b0;
        walker_level = LEVEL_LAST;
      end else if (walker_level == LEVEL_LAST) begin
        walker_busy = 1'b0;
        r.kind      = KIND_DONE;
        r.fault     = 1'b1;
      end else begin
        walker_level   = walker_level - 2'd1;
        r.kind         = KIND_READ;
        r.read_address = table_slot(ppn, walker_va, walker_level);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on result %0d, %s: got %h, want %h", received, what, got, want);
    mismatches++;
  endtask

  // call right after a falling edge; returns right after a falling edge, once the request has been accepted
  task automatic put_req(op_e op, logic [63:0] satp, logic [38:0] va, logic [63:0] pte,
                         bit typed, res_t want);
    res_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tdata_i  = {1'b0, pte, va, satp};
    s_axis_tuser_i  = op;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = walk_step(op, satp, va, pte);
    expected_results.push_back(typed ? want : predicted);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] random_pte(int level);
    logic [63:0] pte;
    int          pick;
    pte  = rand64();
    pick = $urandom_range(0, 99);
    if (level > 0 ? pick < 55 : pick < 15) begin
      pte[0]   = 1'b1;
      pte[3:1] = 3'b000;
    end else if (level > 0 ? pick < 90 : pick < 85) begin
      pte[0]   = 1'b1;
      pte[3:1] = 3'($urandom_range(1, 7));
    end else begin
      pte[0] = 1'b0;
    end
    return pte;
  endfunction

  // downstream stall bursts
  initial begin
    m_axis_tready_i = 1'b0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready_i = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 10) - 1;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(m_axis_tdata_o), 64'h0);
      end else begin
        head = expected_results.pop_front();
        if (m_axis_tuser_o !== head.kind)
          report_mismatch("kind", 64'(m_axis_tuser_o), 64'(head.kind));
        if (m_axis_tdata_o[55:0] !== head.read_address)
          report_mismatch("read_address", 64'(m_axis_tdata_o[55:0]),
                          64'(head.read_address));
        if (m_axis_tdata_o[111:56] !== head.xlat_addr)
          report_mismatch("xlat_addr", 64'(m_axis_tdata_o[111:56]), 64'(head.xlat_addr));
        if (m_axis_tdata_o[112] !== head.fault)
          report_mismatch("fault", 64'(m_axis_tdata_o[112]), 64'(head.fault));
      end
      received++;
    end
  end

  initial begin
    logic [63:0] satp;
    logic [38:0] va;
    logic [63:0] pte;
    bit          aborted;
    rst_ni          = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_START;
    s_axis_tvalid_i = 1'b0;
    walker_busy     = 1'b0;
    walker_level    = LEVEL_LAST;
    walker_va       = '0;
    sent            = 0;
    received        = 0;
    mismatches      = 0;
    cycles          = 0;
    quiet           = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (SCRIPT[i])
      put_req(SCRIPT[i].op, SCRIPT[i].satp, SCRIPT[i].va, SCRIPT[i].pte,
              SCRIPT[i].typed, SCRIPT[i].want);

    while (sent < ITEM_COUNT) begin
      if (sent % 64 < 8)
        quiet = ($urandom_range(0, 3) == 0);
      if (sent + 120 > ITEM_COUNT)
        quiet = 1'b1;
      if ($urandom_range(0, 99) < 70) begin
        // well-formed walk, possibly cut short by the next request
        satp        = rand64();
        satp[63:60] = MODE_SV39;
        va          = 39'(rand64());
        put_req(OP_START, satp, va, 64'h0, 1'b0, NO_RES);
        aborted = 1'b0;
        for (int lvl = 2; lvl >= 0 && walker_busy && !aborted; lvl--) begin
          if ($urandom_range(0, 19) == 0) begin
            aborted = 1'b1;
          end else begin
            pte = random_pte(lvl);
            put_req(OP_RESP, 64'h0, 39'h0, pte, 1'b0, NO_RES);
          end
        end
      end else begin
        satp = rand64();
        if ($urandom_range(0, 1) == 0)
          satp[63:60] = MODE_SV39;
        put_req($urandom_range(0, 1) ? OP_RESP : OP_START, satp, 39'(rand64()), rand64(),
                1'b0, NO_RES);
      end
    end
    s_axis_tvalid_i = 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
